// ===== rtl/ising_pkg.sv =====
// Shared types and constants for the Ising chain Metropolis update block.
`timescale 1ns / 1ps

package ising_pkg;

    localparam int SITE_W      = 10;
    localparam int FRAC_W      = 16;
    localparam int THR_W       = 17;
    localparam int DE_W        = 4;
    localparam int OUT_TOT_W   = 12;
    localparam int MAX_STORE   = 2 ** SITE_W;
    localparam int DEF_CHAIN_LEN = 1024;

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_SET   = 1'b1;
    localparam logic SPIN_DOWN = 1'b0;

    localparam logic signed [DE_W-1:0] DE_UP   = 4'sd4;
    localparam logic signed [DE_W-1:0] DE_ZERO = 4'sd0;
    localparam logic signed [DE_W-1:0] DE_DOWN = -4'sd4;

    typedef struct packed {
        logic              action;
        logic [SITE_W-1:0] site;
        logic              spin_value;
        logic [FRAC_W-1:0] random_fraction;
    } t_in;

    typedef struct packed {
        logic                        flipped;
        logic signed [DE_W-1:0]      energy_change;
        logic signed [OUT_TOT_W-1:0] total_energy;
        logic signed [OUT_TOT_W-1:0] magnetization;
    } t_out;

endpackage

// ===== rtl/ising_spin_mem.sv =====
// Spin store: one bit per site, two registered read ports, one write port.
`timescale 1ns / 1ps

module ising_spin_mem #(
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_a_en,
    input  logic [ADDR_W-1:0] i_rd_a_addr,
    output logic              o_rd_a_data,
    input  logic              i_rd_b_en,
    input  logic [ADDR_W-1:0] i_rd_b_addr,
    output logic              o_rd_b_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_wr_data
);

    logic mem [DEPTH];
    logic r_rd_a;
    logic r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_a_en) begin
            r_rd_a <= mem[i_rd_a_addr];
        end
        if (i_rd_b_en) begin
            r_rd_b <= mem[i_rd_b_addr];
        end
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

// ===== rtl/ising_chain_metropolis_step.sv =====
// Top level: Metropolis flip and forced-set engine for a periodic 1D Ising chain.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | i_in_valid/o_in_stall   | i_in  (action, site, spin, frac)
//   out     | output    | o_out_valid/i_out_stall | o_out (flipped, dE, energy, mag)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (uphill threshold)
//
// An item is handled in order: accept (site and left spin read), right spin read,
// then update and write back. The three-spin fetch over the store's two read
// ports calls for the separate right spin read.
// After reset a clearing pass writes every stored spin down, one site a cycle, over
// min(CHAIN_LEN, 1024) sites; o_in_stall is high meanwhile, cfg is taken as ever.
// A finished result waits in the output register while the next item is accepted;
// the update step waits only if that register is still full and stalled.
`timescale 1ns / 1ps

module ising_chain_metropolis_step #(
    parameter int CHAIN_LEN = ising_pkg::DEF_CHAIN_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ising_pkg::t_in             i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ising_pkg::t_out            o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ising_pkg::THR_W-1:0] i_cfg_data
);

    import ising_pkg::*;

    localparam int STORE_DEPTH = (CHAIN_LEN < MAX_STORE) ? CHAIN_LEN : MAX_STORE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = ($clog2(CHAIN_LEN) + 1 > SITE_W + 1) ?
                                 $clog2(CHAIN_LEN) + 1 : SITE_W + 1;
    localparam int TOT_W       = ($clog2(CHAIN_LEN + 1) + 1 > OUT_TOT_W) ?
                                 $clog2(CHAIN_LEN + 1) + 1 : OUT_TOT_W;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_CALC = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [ADDR_W-1:0]      r_clr_cnt;
    logic [THR_W-1:0]       r_thr;
    t_in                    r_item;
    logic                   r_in_range;
    logic                   r_right_ok;
    logic [ADDR_W-1:0]      r_right_addr;
    logic                   r_left_ok;
    logic                   r_left;
    logic signed [TOT_W-1:0] r_energy;
    logic signed [TOT_W-1:0] r_mag;
    logic                   r_out_valid;
    t_out                   r_out;

    logic                   w_accept;
    logic [IDX_W-1:0]       w_site;
    logic [IDX_W-1:0]       w_left_idx;
    logic [IDX_W-1:0]       w_right_idx;
    logic                   w_in_range;
    logic                   w_left_ok;
    logic                   w_right_ok;

    logic                   w_rd_a;
    logic                   w_rd_b;
    logic                   w_rd_a_en;
    logic                   w_rd_b_en;
    logic [ADDR_W-1:0]      w_rd_b_addr;
    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic                   w_wr_data;

    logic                   w_spin;
    logic                   w_right;
    logic                   w_eq_l;
    logic                   w_eq_r;
    logic signed [DE_W-1:0] w_delta;
    logic signed [DE_W-1:0] w_de;
    logic                   w_flip;
    logic                   w_out_free;
    logic                   w_load;
    logic signed [TOT_W-1:0] n_energy;
    logic signed [TOT_W-1:0] n_mag;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Ring neighbors of the incoming site
    always_comb begin
        w_site      = IDX_W'(i_in.site);
        w_in_range  = (w_site < IDX_W'(CHAIN_LEN));
        w_left_idx  = (w_site == '0) ? IDX_W'(CHAIN_LEN - 1) : w_site - IDX_W'(1);
        w_right_idx = (w_site + IDX_W'(1) >= IDX_W'(CHAIN_LEN)) ? '0 : w_site + IDX_W'(1);
        w_left_ok   = (w_left_idx < IDX_W'(STORE_DEPTH));
        w_right_ok  = (w_right_idx < IDX_W'(STORE_DEPTH));
    end

    // Read site and left neighbor at accept, right neighbor in the cycle after
    always_comb begin
        w_rd_a_en   = w_accept && w_in_range;
        w_rd_b_en   = 1'b0;
        w_rd_b_addr = w_left_idx[ADDR_W-1:0];
        if (w_accept) begin
            w_rd_b_en = w_in_range && w_left_ok;
        end else if (r_state == S_RD2) begin
            w_rd_b_en   = r_in_range && r_right_ok;
            w_rd_b_addr = r_right_addr;
        end
    end

    ising_spin_mem #(
        .DEPTH (STORE_DEPTH)
    ) u_spin_mem (
        .i_clk       (i_clk),
        .i_rd_a_en   (w_rd_a_en),
        .i_rd_a_addr (i_in.site[ADDR_W-1:0]),
        .o_rd_a_data (w_rd_a),
        .i_rd_b_en   (w_rd_b_en),
        .i_rd_b_addr (w_rd_b_addr),
        .o_rd_b_data (w_rd_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data)
    );

    // Flip decision; sites beyond the store read as down
    always_comb begin
        w_spin  = w_rd_a;
        w_right = r_right_ok ? w_rd_b : SPIN_DOWN;
        w_eq_l  = (r_left == w_spin);
        w_eq_r  = (w_spin == w_right);
        if (w_eq_l && w_eq_r) begin
            w_delta = DE_UP;
        end else if (!w_eq_l && !w_eq_r) begin
            w_delta = DE_DOWN;
        end else begin
            w_delta = DE_ZERO;
        end

        w_flip = 1'b0;
        w_de   = DE_ZERO;
        if (r_in_range) begin
            if (r_item.action == ACT_STEP) begin
                w_de   = w_delta;
                w_flip = (w_delta != DE_UP) ||
                         ({1'b0, r_item.random_fraction} < r_thr);
            end else begin
                w_flip = (w_spin != r_item.spin_value);
                w_de   = w_flip ? w_delta : DE_ZERO;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_CALC) && w_out_free;

    always_comb begin
        n_energy = r_energy;
        n_mag    = r_mag;
        if (w_load && w_flip) begin
            n_energy = r_energy + {{(TOT_W - DE_W){w_de[DE_W-1]}}, w_de};
            n_mag    = w_spin ? r_mag - TOT_W'(2) : r_mag + TOT_W'(2);
        end
    end

    // Write port: clearing sweep or flip write-back
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_cnt;
        w_wr_data = SPIN_DOWN;
        if (r_state == S_CLR) begin
            w_wr_en = 1'b1;
        end else if (w_load && w_flip) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_item.site[ADDR_W-1:0];
            w_wr_data = !w_spin;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_thr       <= '0;
            r_energy    <= TOT_W'(0) - TOT_W'(CHAIN_LEN);
            r_mag       <= TOT_W'(0) - TOT_W'(CHAIN_LEN);
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_energy <= n_energy;
            r_mag    <= n_mag;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item       <= i_in;
            r_in_range   <= w_in_range;
            r_left_ok    <= w_left_ok;
            r_right_ok   <= w_right_ok;
            r_right_addr <= w_right_idx[ADDR_W-1:0];
        end
        if (r_state == S_RD2) begin
            r_left <= r_left_ok ? w_rd_b : SPIN_DOWN;
        end
        if (w_load) begin
            r_out.flipped       <= w_flip;
            r_out.energy_change <= w_de;
            r_out.total_energy  <= n_energy[OUT_TOT_W-1:0];
            r_out.magnetization <= n_mag[OUT_TOT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_flip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_flip) |=> (r_energy == $past(r_energy) && r_mag == $past(r_mag)))
        else $error("totals moved without a flip");

    a_flip_mag_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_flip) |=>
            (r_mag - $past(r_mag) == TOT_W'(2) || $past(r_mag) - r_mag == TOT_W'(2)))
        else $error("magnetization step is not two");

    a_uphill_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_flip && r_item.action == ACT_STEP && w_de == DE_UP) |->
            ({1'b0, r_item.random_fraction} < r_thr))
        else $error("uphill flip taken above threshold");

    a_item_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RD2) ##1 (r_state == S_CALC))
        else $error("item did not advance through neighbor read");

endmodule
